### design/pzvc_pkg.sv
// shared types and constants for the pressure zero-volume calibrator
// no dependencies
package pzvc_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_TARGET_PRESSURE   = 3'd0;
  localparam logic [2:0] REG_BAND_THRESHOLD    = 3'd1;
  localparam logic [2:0] REG_FINE_BAND         = 3'd2;
  localparam logic [2:0] REG_STABLE_TIME_LIMIT = 3'd3;
  localparam logic [2:0] REG_FINE_STEP         = 3'd4;
  localparam logic [2:0] REG_COARSE_STEP       = 3'd5;
  localparam logic [2:0] REG_ADC_GAIN          = 3'd6;
  localparam logic [2:0] REG_ADC_OFFSET        = 3'd7;

  localparam int unsigned CFG_DATA_W = 32;

  // motor command codes on the result channel
  localparam logic [1:0] CMD_STOP    = 2'd0;
  localparam logic [1:0] CMD_FORWARD = 2'd1;
  localparam logic [1:0] CMD_BACK    = 2'd2;

  localparam logic signed [23:0] VAL24_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] VAL24_MIN = 24'sh800000;

  typedef enum logic [3:0] {
    MS_STOP    = 4'b0001,
    MS_FORWARD = 4'b0010,
    MS_BACK    = 4'b0100,
    MS_IDLE    = 4'b1000
  } motor_state_t;

  typedef struct packed {
    logic signed [23:0] target_pressure;
    logic        [21:0] band_threshold;
    logic        [22:0] fine_band;
    logic        [31:0] stable_time_limit;
    logic signed [23:0] fine_step;
    logic signed [23:0] coarse_step;
    logic signed [23:0] adc_gain;
    logic signed [23:0] adc_offset;
  } cfg_t;

  typedef struct packed {
    logic        [1:0]  motor_command;
    logic signed [23:0] angle_step;
    logic signed [23:0] pressure_value;
    logic               is_calibrated;
    logic signed [31:0] zero_volume_angle;
  } result_t;

endpackage

### design/pzvc_scale.sv
// linear scaling of the converter code to pressure, rounded and saturated
// depends on pzvc_pkg
module pzvc_scale (
  input  logic        [11:0] adc_code,
  input  logic signed [23:0] adc_gain,
  input  logic signed [23:0] adc_offset,
  output logic signed [23:0] pressure
);

  logic signed [36:0] product;
  logic signed [36:0] rounded;
  logic signed [20:0] quotient;
  logic signed [25:0] sum;

  always_comb begin
    product  = $signed({1'b0, adc_code}) * adc_gain;
    // round half toward plus infinity
    rounded  = product + 37'sd32768;
    quotient = rounded[36:16];
    sum      = {{5{quotient[20]}}, quotient} + {{2{adc_offset[23]}}, adc_offset};
    if (sum > 26'sd8388607) begin
      pressure = pzvc_pkg::VAL24_MAX;
    end else if (sum < -26'sd8388608) begin
      pressure = pzvc_pkg::VAL24_MIN;
    end else begin
      pressure = sum[23:0];
    end
  end

endmodule

### design/pzvc_ctrl.sv
// motor state decision, stop timing and calibration latch
// depends on pzvc_pkg
module pzvc_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      fire,
  input  pzvc_pkg::cfg_t            cfg,
  input  logic signed [23:0]        pressure,
  input  logic        [31:0]        now_ms,
  input  logic signed [31:0]        encoder_angle,
  output pzvc_pkg::result_t         result
);

  pzvc_pkg::motor_state_t motor_state, motor_state_next;
  logic               low_reached, low_reached_next;
  logic               calibrated, calibrated_next;
  logic        [31:0] stop_start, stop_start_next;
  logic        [31:0] stopped_duration, stopped_duration_next;
  logic signed [31:0] captured_angle, captured_angle_next;

  logic        [31:0] start_eff;
  logic               enter_stop;
  logic signed [25:0] p_ext, target_ext, lower, lower2, upper;
  logic signed [24:0] err;
  logic        [24:0] abs_err;
  logic signed [23:0] step_sel;
  logic signed [23:0] step;
  logic        [1:0]  cmd;

  always_comb begin
    p_ext      = {{2{pressure[23]}}, pressure};
    target_ext = {{2{cfg.target_pressure[23]}}, cfg.target_pressure};
    lower      = target_ext - $signed({4'b0, cfg.band_threshold});
    lower2     = target_ext - $signed({3'b0, cfg.band_threshold, 1'b0});
    upper      = target_ext + $signed({4'b0, cfg.band_threshold});
    err        = {pressure[23], pressure} - {cfg.target_pressure[23], cfg.target_pressure};
    abs_err    = err[24] ? 25'(-err) : 25'(err);
  end

  always_comb begin
    motor_state_next      = motor_state;
    low_reached_next      = low_reached;
    calibrated_next       = calibrated;
    stopped_duration_next = stopped_duration;
    captured_angle_next   = captured_angle;
    enter_stop            = 1'b0;
    // first item after reset starts the stop clock
    start_eff       = (motor_state == pzvc_pkg::MS_IDLE) ? now_ms : stop_start;
    stop_start_next = start_eff;

    if (!calibrated && (stopped_duration < cfg.stable_time_limit)) begin
      if (p_ext < lower) begin
        low_reached_next = 1'b1;
        if (p_ext > lower2) begin
          enter_stop = 1'b1;
        end else begin
          motor_state_next = pzvc_pkg::MS_FORWARD;
        end
      end else if (low_reached) begin
        if (p_ext <= upper) begin
          enter_stop = 1'b1;
        end else begin
          motor_state_next = pzvc_pkg::MS_BACK;
          low_reached_next = 1'b0;
        end
      end else begin
        motor_state_next = pzvc_pkg::MS_BACK;
      end
    end else begin
      calibrated_next       = 1'b1;
      captured_angle_next   = encoder_angle;
      motor_state_next      = pzvc_pkg::MS_STOP;
      stopped_duration_next = '0;
    end

    if (enter_stop) begin
      motor_state_next = pzvc_pkg::MS_STOP;
      if (motor_state == pzvc_pkg::MS_STOP) begin
        stopped_duration_next = now_ms - start_eff;
      end else begin
        stopped_duration_next = '0;
        stop_start_next       = now_ms;
      end
    end
  end

  // step size and direction
  always_comb begin
    step_sel = (abs_err < {2'b0, cfg.fine_band}) ? cfg.fine_step : cfg.coarse_step;
    unique case (motor_state_next)
      pzvc_pkg::MS_FORWARD: begin
        cmd  = pzvc_pkg::CMD_FORWARD;
        step = step_sel;
      end
      pzvc_pkg::MS_BACK: begin
        cmd  = pzvc_pkg::CMD_BACK;
        step = (step_sel == pzvc_pkg::VAL24_MIN) ? pzvc_pkg::VAL24_MAX : 24'(-step_sel);
      end
      default: begin
        cmd  = pzvc_pkg::CMD_STOP;
        step = '0;
      end
    endcase
  end

  always_comb begin
    result.motor_command     = cmd;
    result.angle_step        = step;
    result.pressure_value    = pressure;
    result.is_calibrated     = calibrated_next;
    result.zero_volume_angle = captured_angle_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      motor_state      <= pzvc_pkg::MS_IDLE;
      low_reached      <= 1'b0;
      calibrated       <= 1'b0;
      stop_start       <= '0;
      stopped_duration <= '0;
      captured_angle   <= '0;
    end else if (fire) begin
      motor_state      <= motor_state_next;
      low_reached      <= low_reached_next;
      calibrated       <= calibrated_next;
      stop_start       <= stop_start_next;
      stopped_duration <= stopped_duration_next;
      captured_angle   <= captured_angle_next;
    end
  end

endmodule

### design/pressure_zero_volume_calibrator_unit.sv
// pressure zero-volume calibrator, top level
// path from input transfer to result transfer: input reg, then result reg
// throughput: one item per cycle while the result channel is not stalled, scaling and motor state update in one pass
// a stalled result holds the input register, so in_stall follows out_stall while both registers hold an item
// reset (rst, synchronous): pipeline empty, configuration and state registers 0, motor state not started
// depends on pzvc_pkg, pzvc_scale, pzvc_ctrl
module pressure_zero_volume_calibrator_unit (
  input  logic                              clk,
  input  logic                              rst,
  // configuration write port
  input  logic                              cfg_write,
  input  logic [2:0]                        cfg_index,
  input  logic [pzvc_pkg::CFG_DATA_W-1:0]   cfg_data,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic        [11:0]                adc_code,
  input  logic        [31:0]                now_ms,
  input  logic signed [31:0]                encoder_angle,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic        [1:0]                 motor_command,
  output logic signed [23:0]                angle_step,
  output logic signed [23:0]                pressure_value,
  output logic                              is_calibrated,
  output logic signed [31:0]                zero_volume_angle
);

  pzvc_pkg::cfg_t    cfg;
  pzvc_pkg::result_t ctrl_result;

  // input register
  logic               s1_valid;
  logic        [11:0] s1_code;
  logic        [31:0] s1_now;
  logic signed [31:0] s1_angle;
  logic signed [23:0] scaled;

  // handshake between input register and result register
  logic out_adv, s1_fire, s1_free, in_fire;

  always_comb begin
    out_adv  = !out_valid || !out_stall;
    s1_fire  = s1_valid && out_adv;
    s1_free  = !s1_valid || out_adv;
    in_stall = !s1_free;
    in_fire  = in_valid && !in_stall;
  end

  // configuration registers; the user must write them only while idle, the block itself does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        pzvc_pkg::REG_TARGET_PRESSURE:   cfg.target_pressure   <= cfg_data[23:0];
        pzvc_pkg::REG_BAND_THRESHOLD:    cfg.band_threshold    <= cfg_data[21:0];
        pzvc_pkg::REG_FINE_BAND:         cfg.fine_band         <= cfg_data[22:0];
        pzvc_pkg::REG_STABLE_TIME_LIMIT: cfg.stable_time_limit <= cfg_data[31:0];
        pzvc_pkg::REG_FINE_STEP:         cfg.fine_step         <= cfg_data[23:0];
        pzvc_pkg::REG_COARSE_STEP:       cfg.coarse_step       <= cfg_data[23:0];
        pzvc_pkg::REG_ADC_GAIN:          cfg.adc_gain          <= cfg_data[23:0];
        pzvc_pkg::REG_ADC_OFFSET:        cfg.adc_offset        <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid  <= in_fire || (s1_valid && !s1_fire);
      out_valid <= s1_fire || (out_valid && out_stall);
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_code  <= adc_code;
      s1_now   <= now_ms;
      s1_angle <= encoder_angle;
    end
    if (s1_fire) begin
      motor_command     <= ctrl_result.motor_command;
      angle_step        <= ctrl_result.angle_step;
      pressure_value    <= ctrl_result.pressure_value;
      is_calibrated     <= ctrl_result.is_calibrated;
      zero_volume_angle <= ctrl_result.zero_volume_angle;
    end
  end

  pzvc_scale u_scale (
    .adc_code   (s1_code),
    .adc_gain   (cfg.adc_gain),
    .adc_offset (cfg.adc_offset),
    .pressure   (scaled)
  );

  // state advances once per item, as it moves into the result register
  pzvc_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .fire          (s1_fire),
    .cfg           (cfg),
    .pressure      (scaled),
    .now_ms        (s1_now),
    .encoder_angle (s1_angle),
    .result        (ctrl_result)
  );

`ifndef SYNTHESIS
  // once calibrated, the motor is always stopped
  assert property (@(posedge clk) disable iff (rst)
    out_valid && is_calibrated |-> motor_command == pzvc_pkg::CMD_STOP && angle_step == 0)
    else $error("motor moves after calibration");

  // calibrated never drops between results
  assert property (@(posedge clk) disable iff (rst)
    out_valid && $past(out_valid && is_calibrated) |-> is_calibrated)
    else $error("calibrated flag dropped");

  // input is held off only while the input register is occupied
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid)
    else $error("input stalled with empty input register");

  // a new result comes only from a filled input register
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_valid))
    else $error("result without input register item");
`endif

endmodule
